>>> rtl/core/lfps_pkg.sv
// shared types, constants and codes for the line follow pid steering block
// used by lfps_ram-free datapath: lfps_serial_unit and line_follow_pid_steering
`default_nettype none

package lfps_pkg;

   // default sensor width and fixed field widths
   localparam int SAMPLE_BITS_DEF = 10;
   localparam int DT_W            = 16;
   localparam int GAIN_W          = 16;
   localparam int POWER_W         = 8;
   localparam int MODE_W          = 2;
   localparam int TURN_W          = 10;
   localparam int RSP_DATA_W      = ((2 * POWER_W + 7) / 8) * 8;
   localparam int ACC_W_MIN       = 48;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_LIMIT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_LIM  = 3'd6;

   // register reset values
   localparam int                  TARGET_RST = 500;
   localparam int                  LOW_RST    = 200;
   localparam int                  HIGH_RST   = 600;
   localparam logic signed [7:0]   BASE_RST   = 8'sd80;
   localparam logic [GAIN_W-1:0]   GAIN_P_RST = 16'd200;
   localparam logic [GAIN_W-1:0]   GAIN_I_RST = 16'd20;
   localparam logic [GAIN_W-1:0]   GAIN_D_RST = 16'd2;

   localparam logic [GAIN_W-1:0]   SCALE      = 16'd1000;
   localparam logic [DT_W-1:0]     DT_ONE     = 16'd1;

   localparam logic signed [TURN_W-1:0]  LIMIT_POS_W = 10'sd100;
   localparam logic signed [TURN_W-1:0]  LIMIT_NEG_W = -10'sd100;
   localparam logic signed [TURN_W-1:0]  TURN_SAT    = 10'sd256;
   localparam logic signed [POWER_W-1:0] POWER_POS   = 8'sd100;
   localparam logic signed [POWER_W-1:0] POWER_NEG   = -8'sd100;

   // drive mode codes
   localparam logic [MODE_W-1:0] MODE_PID  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOW  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HIGH = 2'd2;

   typedef enum logic [0:0] {
      OP_MUL,
      OP_DIV
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_EDT,
      ST_INTEG,
      ST_MUL_P,
      ST_MUL_I,
      ST_DIV_I,
      ST_MUL_D,
      ST_MUL_K,
      ST_DIV_D,
      ST_DIV_T,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/line_follow_pid_steering.sv
// line follow pid steering: one beat in, one beat out per light sample.
// a pid sample runs its multiplies and divides one at a time on the shared
// bit-serial unit, ACC_W = max(48, SAMPLE_BITS + 28); a spin sample runs
// only the error-times-dt multiply before its result.
// req_tready returns in the same cycle that the registered result appears on rsp_tvalid.
// synchronous active-high reset restores register defaults, clears state.
`default_nettype none

module line_follow_pid_steering #(
   parameter int SAMPLE_BITS = lfps_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // light_sample [SAMPLE_BITS-1:0], elapsed_ms [SAMPLE_BITS+15:SAMPLE_BITS]
   input  wire  [((SAMPLE_BITS+lfps_pkg::DT_W+7)/8)*8-1:0] req_tdata,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // left_power [7:0], right_power [15:8]
   output logic [lfps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // drive_mode [1:0]
   output logic [lfps_pkg::MODE_W-1:0]         rsp_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   input  wire                                 csr_wr_en,
   input  wire  [lfps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [lfps_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int DT_W  = lfps_pkg::DT_W;
   localparam int ACC_W = (SB + 28 > lfps_pkg::ACC_W_MIN) ? SB + 28 : lfps_pkg::ACC_W_MIN;
   localparam int IW    = (SB + 18 > 34) ? SB + 18 : 34;
   localparam int TW    = lfps_pkg::TURN_W;

   localparam logic signed [IW-1:0] INT_MAX = $signed({{(IW-32){1'b0}}, 32'h7FFF_FFFF});
   localparam logic signed [IW-1:0] INT_MIN = $signed({{(IW-32){1'b1}}, 32'h8000_0000});

   // configuration registers
   logic [SB-1:0]                      target_ff, low_ff, high_ff;
   logic signed [7:0]                  base_ff;
   logic [lfps_pkg::GAIN_W-1:0]        gain_p_ff, gain_i_ff, gain_d_ff;

   lfps_pkg::state_type                state_ff, state_in;
   logic                               issued_ff, issued_in;

   logic [SB-1:0]                      sample_ff, sample_in;
   logic [DT_W-1:0]                    dt_ff, dt_in;
   logic signed [SB:0]                 err_ff, err_in;
   logic signed [SB:0]                 prev_ff, prev_in;
   logic signed [SB+1:0]               deriv_ff, deriv_in;
   logic signed [31:0]                 integ_ff, integ_in;
   logic signed [ACC_W-1:0]            turn_ff, turn_in;
   logic signed [TW-1:0]               tsat_ff, tsat_in;
   logic [lfps_pkg::MODE_W-1:0]        mode_ff, mode_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]                  left_ff, left_in, right_ff, right_in;
   logic [lfps_pkg::MODE_W-1:0]        rsp_mode_ff, rsp_mode_in;

   // serial unit
   lfps_pkg::unit_cmd_type             unit_cmd;
   lfps_pkg::unit_stat_type            unit_stat;
   logic [ACC_W-1:0]                   unit_a;
   logic [lfps_pkg::GAIN_W-1:0]        unit_b;
   logic [ACC_W-1:0]                   unit_result;
   logic                               op_state;
   logic                               op_done;
   logic                               rsp_load;

   // datapath helpers
   logic [SB-1:0]                      req_sample;
   logic [DT_W-1:0]                    req_dt;
   logic signed [SB:0]                 err_neg;
   logic [SB-1:0]                      err_mag;
   logic [31:0]                        integ_neg;
   logic signed [SB+1:0]               deriv_neg;
   logic signed [ACC_W-1:0]            turn_neg;
   logic [ACC_W-1:0]                   res_neg;
   logic [IW-1:0]                      edt_ext, edt_signed, integ_ext;
   logic signed [IW-1:0]               isum;
   logic signed [31:0]                 iclamp;
   logic [lfps_pkg::MODE_W-1:0]        mode_calc;
   logic signed [TW-1:0]               tmag;
   logic signed [TW-1:0]               base_ext, lsum, rsum, lsat, rsat;

   lfps_serial_unit #(
      .ACC_W (ACC_W)
   ) u_serial (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .a_in   (unit_a),
      .b_in   (unit_b),
      .stat   (unit_stat),
      .result (unit_result)
   );

   assign op_done  = unit_stat.done && issued_ff;
   assign rsp_load = (state_ff == lfps_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfps_pkg::ST_IDLE:    if (req_tvalid) state_in = lfps_pkg::ST_MUL_EDT;
         lfps_pkg::ST_MUL_EDT: if (op_done) state_in = lfps_pkg::ST_INTEG;
         lfps_pkg::ST_INTEG: begin
            if (mode_calc == lfps_pkg::MODE_PID) state_in = lfps_pkg::ST_MUL_P;
            else state_in = lfps_pkg::ST_FINISH;
         end
         lfps_pkg::ST_MUL_P:   if (op_done) state_in = lfps_pkg::ST_MUL_I;
         lfps_pkg::ST_MUL_I:   if (op_done) state_in = lfps_pkg::ST_DIV_I;
         lfps_pkg::ST_DIV_I:   if (op_done) state_in = lfps_pkg::ST_MUL_D;
         lfps_pkg::ST_MUL_D:   if (op_done) state_in = lfps_pkg::ST_MUL_K;
         lfps_pkg::ST_MUL_K:   if (op_done) state_in = lfps_pkg::ST_DIV_D;
         lfps_pkg::ST_DIV_D:   if (op_done) state_in = lfps_pkg::ST_DIV_T;
         lfps_pkg::ST_DIV_T:   if (op_done) state_in = lfps_pkg::ST_FINISH;
         lfps_pkg::ST_FINISH:  if (rsp_load) state_in = lfps_pkg::ST_IDLE;
         default:              state_in = lfps_pkg::ST_IDLE;
      endcase
   end

   // state outputs: handshake and unit operands
   always_comb begin
      req_tready  = (state_ff == lfps_pkg::ST_IDLE);
      op_state    = 1'b1;
      unit_cmd.op = lfps_pkg::OP_MUL;
      unit_a      = '0;
      unit_b      = '0;
      case (state_ff)
         lfps_pkg::ST_MUL_EDT: begin
            unit_a = ACC_W'(err_mag);
            unit_b = dt_ff;
         end
         lfps_pkg::ST_MUL_P: begin
            unit_a = ACC_W'(err_mag);
            unit_b = gain_p_ff;
         end
         lfps_pkg::ST_MUL_I: begin
            unit_a = ACC_W'(integ_ff[31] ? integ_neg : integ_ff);
            unit_b = gain_i_ff;
         end
         lfps_pkg::ST_DIV_I: begin
            unit_cmd.op = lfps_pkg::OP_DIV;
            unit_a      = unit_result;
            unit_b      = lfps_pkg::SCALE;
         end
         lfps_pkg::ST_MUL_D: begin
            unit_a = ACC_W'(deriv_ff[SB+1] ? deriv_neg[SB:0] : deriv_ff[SB:0]);
            unit_b = gain_d_ff;
         end
         lfps_pkg::ST_MUL_K: begin
            unit_a = unit_result;
            unit_b = lfps_pkg::SCALE;
         end
         lfps_pkg::ST_DIV_D: begin
            unit_cmd.op = lfps_pkg::OP_DIV;
            unit_a      = unit_result;
            unit_b      = dt_ff;
         end
         lfps_pkg::ST_DIV_T: begin
            unit_cmd.op = lfps_pkg::OP_DIV;
            unit_a      = turn_ff[ACC_W-1] ? turn_neg : turn_ff;
            unit_b      = lfps_pkg::SCALE;
         end
         default: begin
            op_state = 1'b0;
         end
      endcase
      unit_cmd.start = op_state && !issued_ff;
   end

   always_comb begin
      if (op_done) issued_in = 1'b0;
      else if (unit_cmd.start) issued_in = 1'b1;
      else issued_in = issued_ff;
   end

   // datapath
   always_comb begin
      req_sample = req_tdata[SB-1:0];
      req_dt     = req_tdata[SB+DT_W-1:SB];

      err_neg   = -err_ff;
      err_mag   = err_ff[SB] ? err_neg[SB-1:0] : err_ff[SB-1:0];
      integ_neg = -integ_ff;
      deriv_neg = -deriv_ff;
      turn_neg  = -turn_ff;
      res_neg   = -unit_result;

      // integral update, saturated to 32 bits
      edt_ext    = {{(IW-SB-DT_W){1'b0}}, unit_result[SB+DT_W-1:0]};
      edt_signed = err_ff[SB] ? -edt_ext : edt_ext;
      integ_ext  = {{(IW-32){integ_ff[31]}}, integ_ff};
      isum       = $signed(integ_ext + edt_signed);
      if (isum > INT_MAX) iclamp = 32'sh7FFF_FFFF;
      else if (isum < INT_MIN) iclamp = $signed(32'h8000_0000);
      else iclamp = isum[31:0];

      if (sample_ff < low_ff) mode_calc = lfps_pkg::MODE_LOW;
      else if (sample_ff > high_ff) mode_calc = lfps_pkg::MODE_HIGH;
      else mode_calc = lfps_pkg::MODE_PID;

      tmag = (|unit_result[ACC_W-1:8]) ? lfps_pkg::TURN_SAT : $signed({2'b00, unit_result[7:0]});

      base_ext = {{(TW-8){base_ff[7]}}, base_ff};
      lsum     = base_ext + tsat_ff;
      rsum     = base_ext - tsat_ff;
      if (lsum > lfps_pkg::LIMIT_POS_W) lsat = lfps_pkg::LIMIT_POS_W;
      else if (lsum < lfps_pkg::LIMIT_NEG_W) lsat = lfps_pkg::LIMIT_NEG_W;
      else lsat = lsum;
      if (rsum > lfps_pkg::LIMIT_POS_W) rsat = lfps_pkg::LIMIT_POS_W;
      else if (rsum < lfps_pkg::LIMIT_NEG_W) rsat = lfps_pkg::LIMIT_NEG_W;
      else rsat = rsum;

      sample_in    = sample_ff;
      dt_in        = dt_ff;
      err_in       = err_ff;
      prev_in      = prev_ff;
      deriv_in     = deriv_ff;
      integ_in     = integ_ff;
      turn_in      = turn_ff;
      tsat_in      = tsat_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      left_in      = left_ff;
      right_in     = right_ff;
      rsp_mode_in  = rsp_mode_ff;

      case (state_ff)
         lfps_pkg::ST_IDLE: begin
            sample_in = req_sample;
            dt_in     = (req_dt == '0) ? lfps_pkg::DT_ONE : req_dt;
            err_in    = $signed({1'b0, req_sample}) - $signed({1'b0, target_ff});
         end
         lfps_pkg::ST_INTEG: begin
            // cleared when its sign opposes the error
            if ((!err_ff[SB] && err_ff != '0 && iclamp < 0) || (err_ff[SB] && iclamp > 0))
               integ_in = '0;
            else
               integ_in = iclamp;
            deriv_in = $signed({err_ff[SB], err_ff}) - $signed({prev_ff[SB], prev_ff});
            prev_in  = err_ff;
            mode_in  = mode_calc;
         end
         lfps_pkg::ST_MUL_P: begin
            if (op_done) turn_in = $signed(err_ff[SB] ? res_neg : unit_result);
         end
         lfps_pkg::ST_DIV_I: begin
            if (op_done) turn_in = turn_ff + $signed(integ_ff[31] ? res_neg : unit_result);
         end
         lfps_pkg::ST_DIV_D: begin
            if (op_done) turn_in = turn_ff + $signed(deriv_ff[SB+1] ? res_neg : unit_result);
         end
         lfps_pkg::ST_DIV_T: begin
            if (op_done) tsat_in = turn_ff[ACC_W-1] ? -tmag : tmag;
         end
         lfps_pkg::ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_mode_in  = mode_ff;
               case (mode_ff)
                  lfps_pkg::MODE_LOW: begin
                     left_in  = lfps_pkg::POWER_NEG;
                     right_in = lfps_pkg::POWER_POS;
                  end
                  lfps_pkg::MODE_HIGH: begin
                     left_in  = lfps_pkg::POWER_POS;
                     right_in = lfps_pkg::POWER_NEG;
                  end
                  default: begin
                     left_in  = lsat[7:0];
                     right_in = rsat[7:0];
                  end
               endcase
            end
         end
         default: begin
            turn_in = turn_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfps_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
      end
      sample_ff   <= sample_in;
      dt_ff       <= dt_in;
      err_ff      <= err_in;
      deriv_ff    <= deriv_in;
      turn_ff     <= turn_in;
      tsat_ff     <= tsat_in;
      mode_ff     <= mode_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      rsp_mode_ff <= rsp_mode_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= SB'(lfps_pkg::TARGET_RST);
         base_ff   <= lfps_pkg::BASE_RST;
         gain_p_ff <= lfps_pkg::GAIN_P_RST;
         gain_i_ff <= lfps_pkg::GAIN_I_RST;
         gain_d_ff <= lfps_pkg::GAIN_D_RST;
         low_ff    <= SB'(lfps_pkg::LOW_RST);
         high_ff   <= SB'(lfps_pkg::HIGH_RST);
      end else if (csr_wr_en) begin
         case (csr_index)
            lfps_pkg::CSR_TARGET:    target_ff <= csr_wdata[SB-1:0];
            lfps_pkg::CSR_BASE:      base_ff   <= csr_wdata[7:0];
            lfps_pkg::CSR_GAIN_P:    gain_p_ff <= csr_wdata;
            lfps_pkg::CSR_GAIN_I:    gain_i_ff <= csr_wdata;
            lfps_pkg::CSR_GAIN_D:    gain_d_ff <= csr_wdata;
            lfps_pkg::CSR_LOW_LIMIT: low_ff    <= csr_wdata[SB-1:0];
            lfps_pkg::CSR_HIGH_LIM:  high_ff   <= csr_wdata[SB-1:0];
            default:                 base_ff   <= base_ff;
         endcase
      end
   end

   assign rsp_tdata  = {right_ff, left_ff};
   assign rsp_tuser  = rsp_mode_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // the serial unit is never mid-operation while a new beat can be taken
   a_idle_unit: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !unit_stat.busy)
      else $error("serial unit busy while accepting a beat");

   // a finished operation always belongs to a command this sequencer issued
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      unit_stat.done |-> issued_ff)
      else $error("serial unit done without an issued command");

   a_power_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (left_ff >= lfps_pkg::POWER_NEG && left_ff <= lfps_pkg::POWER_POS &&
                      right_ff >= lfps_pkg::POWER_NEG && right_ff <= lfps_pkg::POWER_POS))
      else $error("motor power outside saturation range");

   a_low_spin: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == lfps_pkg::MODE_LOW) |->
         (left_ff == lfps_pkg::POWER_NEG && right_ff == lfps_pkg::POWER_POS))
      else $error("low spin beat carries wrong power");

endmodule

`default_nettype wire

>>> rtl/core/lfps_serial_unit.sv
// bit-serial unsigned multiply (shift-add, msb of multiplier first) and
// restoring divide, one bit per cycle; depends on lfps_pkg
`default_nettype none

module lfps_serial_unit #(
   parameter int ACC_W = lfps_pkg::ACC_W_MIN
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire lfps_pkg::unit_cmd_type  cmd,
   input  wire [ACC_W-1:0]              a_in,
   input  wire [lfps_pkg::GAIN_W-1:0]   b_in,
   output lfps_pkg::unit_stat_type      stat,
   output logic [ACC_W-1:0]             result
);

   localparam int CNT_W = $clog2(ACC_W + 1);
   localparam int B_W   = lfps_pkg::GAIN_W;

   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [ACC_W-1:0]      mcand_ff, mcand_in;
   logic [B_W-1:0]        opb_ff, opb_in;
   logic [B_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   lfps_pkg::op_type      op_ff, op_in;
   logic                  done_ff, done_in;
   logic [B_W:0]          rem_shift;
   logic [B_W:0]          rem_trial;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      opb_in    = opb_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      done_in   = 1'b0;
      rem_shift = {rem_ff, acc_ff[ACC_W-1]};
      rem_trial = rem_shift - {1'b0, opb_ff};
      if (cmd.start) begin
         op_in    = cmd.op;
         mcand_in = a_in;
         opb_in   = b_in;
         rem_in   = '0;
         case (cmd.op)
            lfps_pkg::OP_MUL: begin
               acc_in = '0;
               cnt_in = CNT_W'(B_W);
            end
            lfps_pkg::OP_DIV: begin
               acc_in = a_in;
               cnt_in = CNT_W'(ACC_W);
            end
            default: begin
               acc_in = '0;
               cnt_in = '0;
            end
         endcase
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
         case (op_ff)
            lfps_pkg::OP_MUL: begin
               acc_in = {acc_ff[ACC_W-2:0], 1'b0} + (opb_ff[B_W-1] ? mcand_ff : '0);
               opb_in = {opb_ff[B_W-2:0], 1'b0};
            end
            lfps_pkg::OP_DIV: begin
               // quotient bits shift in behind the dividend
               if (rem_shift >= {1'b0, opb_ff}) begin
                  rem_in = rem_trial[B_W-1:0];
                  acc_in = {acc_ff[ACC_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_shift[B_W-1:0];
                  acc_in = {acc_ff[ACC_W-2:0], 1'b0};
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
         op_ff   <= lfps_pkg::OP_MUL;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      opb_ff   <= opb_in;
      rem_ff   <= rem_in;
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign result    = acc_ff;

endmodule

`default_nettype wire
